[hdl/dvh_pkg.sv]
package dvh_pkg;

    // Command codes carried on the command input.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDWAIT
    } t_state;

endpackage

[hdl/dvh_ram.sv]
module dvh_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/distinct_value_histogram_unit.sv]
// Distinct-value histogram of samples, kept in order of first appearance.
// A command transfer happens at a rising edge with start high and busy low;
// i_cmd selects insert, read entry or clear. Every command yields exactly one
// result, shown for one cycle with o_done high; the receiver cannot stall it.
// An insert searches the used entries one per cycle through the table
// memory's read port, each entry compared in the cycle after its read. The
// search stops at the first matching slot, or after all used entries when the
// value is new or the table is full. A read of a used entry goes through a
// wait state for the memory read; a dropped insert, a clear, a read past the
// used entries or an unknown command finishes straight from idle. busy falls
// as the result appears, so the next command can be taken at the edge that
// ends the result cycle.
// busy is high while a search or a read is under way.
// Reset empties the table at once by zeroing the used-entry count; the
// memory itself is not cleared, since only slots below that count are read.
module distinct_value_histogram_unit
    import dvh_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int SAMPLE_BITS   = 12,
    parameter int COUNT_BITS    = 16,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES),
    localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_sample_dropped,
    input  logic [IDX_W-1:0]       i_entry_index,
    output logic                   o_done,
    output logic [IDX_W-1:0]       o_slot,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic [COUNT_BITS-1:0]  o_occurrences,
    output logic                   o_new_entry,
    output logic                   o_table_full,
    output logic                   o_entry_valid,
    output logic [CNT_W-1:0]       o_used_entries
);

    localparam int RAM_W = SAMPLE_BITS + COUNT_BITS;

    t_state                 r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [CNT_W-1:0]       r_addr, n_addr;
    logic [IDX_W-1:0]       r_cmp_addr, n_cmp_addr;
    logic                   r_pend, n_pend;
    logic [CNT_W-1:0]       r_used, n_used;
    logic                   r_done, n_done;
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic [SAMPLE_BITS-1:0] r_value, n_value;
    logic [COUNT_BITS-1:0]  r_occ, n_occ;
    logic                   r_new, n_new;
    logic                   r_full, n_full;
    logic                   r_valid, n_valid;

    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [RAM_W-1:0]       ram_wdata, ram_rdata;

    logic [SAMPLE_BITS-1:0] rd_value;
    logic [COUNT_BITS-1:0]  rd_count, rd_count_inc;
    logic                   accept, hit, more, miss_end, index_used;

    // Each entry holds the value in its upper bits and the count below.
    dvh_ram #(
        .WIDTH(RAM_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Search and decode terms.
    assign rd_value     = ram_rdata[RAM_W-1:COUNT_BITS];
    assign rd_count     = ram_rdata[COUNT_BITS-1:0];
    assign rd_count_inc = (rd_count == {COUNT_BITS{1'b1}}) ? rd_count
                                                           : rd_count + COUNT_BITS'(1);
    assign accept       = start && (r_state == ST_IDLE);
    assign hit          = r_pend && (rd_value == r_sample);
    assign more         = r_addr < r_used;
    assign miss_end     = !r_pend && !more;
    assign index_used   = CNT_W'(i_entry_index) < r_used;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_INSERT && !i_sample_dropped) begin
                        n_state = ST_SCAN;
                    end else if (i_cmd == CMD_READ && index_used) begin
                        n_state = ST_RDWAIT;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || miss_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDWAIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory accesses, search pointers and result fields.
    always_comb begin
        n_sample   = r_sample;
        n_addr     = r_addr;
        n_cmp_addr = r_cmp_addr;
        n_pend     = 1'b0;
        n_used     = r_used;
        n_done     = 1'b0;
        n_slot     = r_slot;
        n_value    = r_value;
        n_occ      = r_occ;
        n_new      = r_new;
        n_full     = r_full;
        n_valid    = r_valid;
        ram_we     = 1'b0;
        ram_waddr  = r_cmp_addr;
        ram_wdata  = {rd_value, rd_count_inc};
        ram_re     = 1'b0;
        ram_raddr  = r_addr[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_sample = i_sample;
                    n_addr   = '0;
                    // Result fields start at zero; an unused-entry read sets the slot.
                    n_slot   = '0;
                    n_value  = '0;
                    n_occ    = '0;
                    n_new    = 1'b0;
                    n_full   = 1'b0;
                    n_valid  = 1'b0;
                    case (i_cmd)
                        CMD_INSERT: begin
                            n_done = i_sample_dropped;
                        end
                        CMD_READ: begin
                            if (index_used) begin
                                ram_re     = 1'b1;
                                ram_raddr  = i_entry_index;
                                n_cmp_addr = i_entry_index;
                            end else begin
                                n_slot = i_entry_index;
                                n_done = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_used = '0;
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // Matching entry: write back the count plus one, held at its maximum.
                    ram_we    = 1'b1;
                    ram_waddr = r_cmp_addr;
                    ram_wdata = {rd_value, rd_count_inc};
                    n_slot    = r_cmp_addr;
                    n_value   = rd_value;
                    n_occ     = rd_count_inc;
                    n_valid   = 1'b1;
                    n_done    = 1'b1;
                end else if (miss_end) begin
                    n_done = 1'b1;
                    if (r_used >= CNT_W'(TABLE_ENTRIES)) begin
                        n_value = r_sample;
                        n_full  = 1'b1;
                    end else begin
                        // New distinct value goes to the first free slot.
                        ram_we    = 1'b1;
                        ram_waddr = r_used[IDX_W-1:0];
                        ram_wdata = {r_sample, COUNT_BITS'(1)};
                        n_used    = r_used + CNT_W'(1);
                        n_slot    = r_used[IDX_W-1:0];
                        n_value   = r_sample;
                        n_occ     = COUNT_BITS'(1);
                        n_new     = 1'b1;
                        n_valid   = 1'b1;
                    end
                end else begin
                    // Read the next used entry; it is compared next cycle.
                    n_pend = more;
                    if (more) begin
                        ram_re     = 1'b1;
                        ram_raddr  = r_addr[IDX_W-1:0];
                        n_cmp_addr = r_addr[IDX_W-1:0];
                        n_addr     = r_addr + CNT_W'(1);
                    end
                end
            end
            ST_RDWAIT: begin
                n_slot  = r_cmp_addr;
                n_value = rd_value;
                n_occ   = rd_count;
                n_valid = 1'b1;
                n_done  = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_used  <= n_used;
            r_done  <= n_done;
        end
        r_sample   <= n_sample;
        r_addr     <= n_addr;
        r_cmp_addr <= n_cmp_addr;
        r_slot     <= n_slot;
        r_value    <= n_value;
        r_occ      <= n_occ;
        r_new      <= n_new;
        r_full     <= n_full;
        r_valid    <= n_valid;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_slot         = r_slot;
    assign o_value        = r_value;
    assign o_occurrences  = r_occ;
    assign o_new_entry    = r_new;
    assign o_table_full   = r_full;
    assign o_entry_valid  = r_valid;
    assign o_used_entries = r_used;

endmodule

[sim/distinct_value_histogram_unit_tb.sv]
`timescale 1ns / 1ps

module distinct_value_histogram_unit_tb;
    import dvh_pkg::*;

    localparam int          TABLE_ENTRIES  = 1024;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int          REPEAT_INSERTS = 24;
    localparam int          FILL_INSERTS   = 32;
    localparam int          CYCLE_LIMIT    = 10_000_000;
    localparam int          PRINT_LIMIT    = 30;

    // One result of the block, in port order.
    typedef struct packed {
        logic [9:0]  slot;
        logic [11:0] value;
        logic [15:0] occurrences;
        logic        new_entry;
        logic        table_full;
        logic        entry_valid;
        logic [10:0] used_entries;
    } t_histo_result;

    // Histogram predictor and the results it still waits for.
    class histo_scoreboard;
        logic [11:0]   value_mem [TABLE_ENTRIES];
        logic [15:0]   count_mem [TABLE_ENTRIES];
        logic [10:0]   used;
        t_histo_result expected_q [$];
        int            errors;
        int            checked;

        function new();
            used    = '0;
            errors  = 0;
            checked = 0;
        endfunction

        // Work out what an accepted command must produce.
        function void note_command(logic [1:0] cmd, logic [11:0] sample, logic dropped,
                                   logic [9:0] index);
            t_histo_result r;
            int            hit;
            int            j;
            r   = '0;
            hit = -1;
            case (cmd)
                CMD_INSERT: begin
                    if (!dropped) begin
                        for (j = 0; j < int'(used) && hit < 0; j++) begin
                            if (value_mem[j] == sample) hit = j;
                        end
                        if (hit >= 0) begin
                            // The count sticks at its maximum once saturated.
                            if (count_mem[hit] != COUNT_MAX) count_mem[hit] += 16'd1;
                            r.slot        = 10'(hit);
                            r.value       = value_mem[hit];
                            r.occurrences = count_mem[hit];
                            r.entry_valid = 1'b1;
                        end else if (int'(used) >= TABLE_ENTRIES) begin
                            r.value      = sample;
                            r.table_full = 1'b1;
                        end else begin
                            value_mem[used] = sample;
                            count_mem[used] = 16'd1;
                            r.slot          = used[9:0];
                            r.value         = sample;
                            r.occurrences   = 16'd1;
                            r.new_entry     = 1'b1;
                            r.entry_valid   = 1'b1;
                            used            = used + 11'd1;
                        end
                    end
                end
                CMD_READ: begin
                    r.slot = index;
                    if (11'(index) < used) begin
                        r.value       = value_mem[index];
                        r.occurrences = count_mem[index];
                        r.entry_valid = 1'b1;
                    end
                end
                CMD_CLEAR: used = '0;
                default: ;
            endcase
            r.used_entries = used;
            expected_q.push_back(r);
        endfunction

        task report_error(string msg);
            errors++;
            if (errors <= PRINT_LIMIT) $display("ERROR: %s", msg);
        endtask

        // Compare one result transfer with the oldest expectation.
        task check_result(t_histo_result got);
            t_histo_result want;
            if (expected_q.size() == 0) begin
                report_error($sformatf("result 0x%0h arrived with nothing expected", got));
            end else begin
                want = expected_q.pop_front();
                if (got.slot !== want.slot)
                    report_error($sformatf("result %0d: slot 0x%0h, expected 0x%0h",
                                           checked, got.slot, want.slot));
                if (got.value !== want.value)
                    report_error($sformatf("result %0d: value 0x%0h, expected 0x%0h",
                                           checked, got.value, want.value));
                if (got.occurrences !== want.occurrences)
                    report_error($sformatf("result %0d: occurrences 0x%0h, expected 0x%0h",
                                           checked, got.occurrences, want.occurrences));
                if (got.new_entry !== want.new_entry)
                    report_error($sformatf("result %0d: new_entry %b, expected %b",
                                           checked, got.new_entry, want.new_entry));
                if (got.table_full !== want.table_full)
                    report_error($sformatf("result %0d: table_full %b, expected %b",
                                           checked, got.table_full, want.table_full));
                if (got.entry_valid !== want.entry_valid)
                    report_error($sformatf("result %0d: entry_valid %b, expected %b",
                                           checked, got.entry_valid, want.entry_valid));
                if (got.used_entries !== want.used_entries)
                    report_error($sformatf("result %0d: used_entries %0d, expected %0d",
                                           checked, got.used_entries, want.used_entries));
            end
            checked++;
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [1:0]    i_cmd;
    logic [11:0]   i_sample;
    logic          i_sample_dropped;
    logic [9:0]    i_entry_index;
    logic          o_done;
    logic [9:0]    o_slot;
    logic [11:0]   o_value;
    logic [15:0]   o_occurrences;
    logic          o_new_entry;
    logic          o_table_full;
    logic          o_entry_valid;
    logic [10:0]   o_used_entries;
    t_histo_result observed;

    histo_scoreboard sb;
    int              cycle_count;
    bit              idle_on;

    distinct_value_histogram_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_sample         (i_sample),
        .i_sample_dropped (i_sample_dropped),
        .i_entry_index    (i_entry_index),
        .o_done           (o_done),
        .o_slot           (o_slot),
        .o_value          (o_value),
        .o_occurrences    (o_occurrences),
        .o_new_entry      (o_new_entry),
        .o_table_full     (o_table_full),
        .o_entry_valid    (o_entry_valid),
        .o_used_entries   (o_used_entries)
    );

    assign observed = {o_slot, o_value, o_occurrences, o_new_entry, o_table_full,
                       o_entry_valid, o_used_entries};

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Cycle counter for the run limit.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL distinct_value_histogram_unit");
        $finish;
    end

    // Watch both sides: check a result first, then note a new command transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) sb.check_result(observed);
            if (start === 1'b1 && busy === 1'b0)
                sb.note_command(i_cmd, i_sample, i_sample_dropped, i_entry_index);
        end
    end

    function automatic logic [11:0] rand_sample();
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [9:0] rand_index();
        return 10'($urandom_range(0, 1023));
    endfunction

    // Sender gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one command and hold it until the block takes the transfer.
    task automatic issue_command(input logic [1:0] c, input logic [11:0] s,
                                 input logic d, input logic [9:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_cmd            <= c;
        i_sample         <= s;
        i_sample_dropped <= d;
        i_entry_index    <= idx;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic insert_sample(input logic [11:0] s);
        issue_command(CMD_INSERT, s, 1'b0, rand_index());
    endtask

    task automatic read_entry(input logic [9:0] idx);
        issue_command(CMD_READ, rand_sample(), 1'(($urandom_range(0, 1))), idx);
    endtask

    task automatic clear_table();
        issue_command(CMD_CLEAR, rand_sample(), 1'(($urandom_range(0, 1))), rand_index());
    endtask

    initial begin
        logic [11:0] pool [64];
        int          pool_n;
        int          r;
        int          hi;
        logic [11:0] offset;
        logic [9:0]  idx;

        sb               = new();
        cycle_count      = 0;
        idle_on          = 1'b1;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_cmd            = CMD_INSERT;
        i_sample         = '0;
        i_sample_dropped = 1'b0;
        i_entry_index    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: empty reads, value extremes, match, dropped, unknown, clear.
        read_entry(10'd0);
        read_entry(10'd1023);
        issue_command(CMD_INSERT, 12'hFFF, 1'b1, 10'd1023);
        insert_sample(12'h000);
        insert_sample(12'hFFF);
        insert_sample(12'h000);
        issue_command(CMD_INSERT, 12'hFFF, 1'b1, 10'd0);
        issue_command(CMD_UNUSED, 12'h000, 1'b0, 10'd0);
        read_entry(10'd0);
        read_entry(10'd1);
        read_entry(10'd2);
        insert_sample(12'hAAA);
        insert_sample(12'h555);
        read_entry(10'd1023);
        clear_table();
        read_entry(10'd0);
        insert_sample(12'h555);
        insert_sample(12'hAAA);
        insert_sample(12'hAAA);
        read_entry(10'd1);
        issue_command(CMD_UNUSED, 12'hFFF, 1'b1, 10'd1023);
        clear_table();

        // Repeated matches on a single slot, back to back.
        idle_on = 1'b0;
        offset  = rand_sample();
        for (int n = 0; n < REPEAT_INSERTS; n++) insert_sample(offset);
        read_entry(10'd0);
        clear_table();

        // Random mix over small working sets of values.
        for (int grp = 0; grp < 10; grp++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            pool_n  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                  : $urandom_range(1, 16);
            for (int p = 0; p < pool_n; p++) pool[p] = rand_sample();
            if ($urandom_range(0, 2) == 0) clear_table();
            if (grp == 5) wait_drained();
            for (int n = 0; n < 48; n++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    issue_command(CMD_INSERT, pool[$urandom_range(0, pool_n - 1)],
                                  1'($urandom_range(0, 9) == 0), rand_index());
                end else if (r < 62) begin
                    issue_command(CMD_INSERT, rand_sample(), 1'($urandom_range(0, 1)),
                                  rand_index());
                end else if (r < 87) begin
                    hi  = int'(sb.used) + 1;
                    idx = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, hi))
                                                      : rand_index();
                    read_entry(idx);
                end else if (r < 91) begin
                    clear_table();
                end else if (r < 95) begin
                    issue_command(CMD_UNUSED, rand_sample(), 1'($urandom_range(0, 1)),
                                  rand_index());
                end else begin
                    issue_command(CMD_INSERT, rand_sample(), 1'b1, rand_index());
                end
            end
        end

        // Fill part of the table with distinct values, then match and read across it.
        idle_on = 1'b1;
        clear_table();
        offset = rand_sample();
        for (int n = 0; n < FILL_INSERTS; n++) insert_sample(12'(n * 7) + offset);
        for (int n = 0; n < 3; n++) insert_sample(12'((FILL_INSERTS + n) * 7) + offset);
        insert_sample(12'((FILL_INSERTS - 1) * 7) + offset);
        insert_sample(offset);
        issue_command(CMD_INSERT, rand_sample(), 1'b1, rand_index());
        read_entry(10'd1023);
        read_entry(10'd512);
        read_entry(10'd0);
        for (int n = 0; n < 6; n++) read_entry(rand_index());
        issue_command(CMD_UNUSED, rand_sample(), 1'b0, rand_index());
        clear_table();
        read_entry(10'd1023);
        insert_sample(rand_sample());

        // Let everything drain and watch a little longer for stray strobes.
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Checked %0d results in %0d cycles.", sb.checked, cycle_count);
        $display("Run covered directed corners, repeated matches on one slot, %s",
                 "a random command mix and a partly filled table read across its range.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS distinct_value_histogram_unit");
        end else begin
            $display("FAIL distinct_value_histogram_unit");
        end
        $finish;
    end

endmodule

[distinct_value_histogram_unit.f]
hdl/dvh_pkg.sv
hdl/dvh_ram.sv
hdl/distinct_value_histogram_unit.sv
sim/distinct_value_histogram_unit_tb.sv
